// ===== design/atms_pkg.sv =====
// Shared widths, constants and types of the trimmed-mean scaler.
// Used by every module of the block; depends on nothing.
package atms_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int CNT_W       = 11;
	localparam int PGA_W       = 3;
	localparam int GAIN_W      = 11;
	localparam int SUM_W       = 27;
	localparam int OUT_W       = 34;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam int MAX_SAMPLES = 1024;
	localparam int MIN_SAMPLES = 3;

	// magnitude of the trimmed sum, of |gain| * 1000 and their product
	localparam int MAG_W       = 26;
	localparam int GMUL_W      = 20;
	localparam int PROD_W      = MAG_W + GMUL_W;
	// reference is 8192 mV = 1 << REF_SHIFT, shifted right by the gain code
	localparam int REF_SHIFT   = 13;
	localparam int NUM_W       = PROD_W + REF_SHIFT;
	// (N - 2) * 32767 stays below 2^25
	localparam int NM2_W       = 10;
	localparam int FS_SHIFT    = 15;
	localparam int DEN_W       = NM2_W + FS_SHIFT;
	localparam int MV_TO_UV    = 1000;

	localparam int MUL_CNT_W   = $clog2(GMUL_W);
	localparam int DIV_CNT_W   = $clog2(NUM_W);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PGA_CODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_GAIN = 2'd2;

	// summary of a finished run, handed from the accumulator to the scaler
	typedef struct packed {
		logic                       fin;
		logic signed [SUM_W-1:0]    sum;
		logic signed [SAMPLE_W-1:0] min;
		logic signed [SAMPLE_W-1:0] max;
	} run_t;

endpackage

// ===== design/adc_trimmed_mean_scaler_top.sv =====
// Top level of the trimmed-mean ADC scaler: configuration registers, run
// sequencer and output register. Depends on atms_pkg, atms_accum, atms_smul, atms_sdiv.
//
// Usage
//  - Input channel (in_valid / in_stall / sample) takes one signed 16-bit
//    converter word per accepted cycle. A word that does not finish a run is
//    absorbed without a stall, so those words stream back to back.
//  - The word that completes a run (sample_count words, clamped to 3..1024)
//    starts the scaling: trimmed sum, a bit-serial multiply by |gain| * 1000
//    and a bit-serial restoring divide by (N - 2) * 32767. In stays stalled
//    meanwhile, until the result is loaded into the output register.
//  - Output channel (out_valid / out_stall / measured_value) carries one
//    signed 34-bit word per run: microvolts times channel gain, truncated
//    toward zero. The result sits in its own register, so the next run's
//    words are taken while it waits; only a further result waits for it.
//  - Configuration: cfg_we writes cfg_data into register cfg_index; write
//    only while the block is idle. Unknown indexes are ignored.
//  - Reset (arst_n low, asynchronous) clears the run and out_valid, and
//    loads sample_count 5, pga_code 2, channel_gain 1.
module adc_trimmed_mean_scaler_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [atms_pkg::SAMPLE_W-1:0]   sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [atms_pkg::OUT_W-1:0]      measured_value,
	input  logic                                   cfg_we,
	input  logic        [atms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [atms_pkg::CFG_DATA_W-1:0] cfg_data
);
	import atms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic        [CNT_W-1:0]  sample_count_q;
	logic        [PGA_W-1:0]  pga_code_q;
	logic signed [GAIN_W-1:0] channel_gain_q;

	// run datapath
	logic signed [SUM_W:0]    trim_q;
	logic        [GMUL_W-1:0] gmag_q;
	logic        [DEN_W-1:0]  den_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  measured_value_q;

	logic        [CNT_W-1:0]  n_eff;
	logic        [NM2_W-1:0]  nm2;
	logic                     take;
	run_t                     run;
	logic signed [SUM_W:0]    trim_nx;
	logic        [GAIN_W-1:0] gain_abs;
	logic        [MAG_W-1:0]  trim_abs;
	logic        [NUM_W-1:0]  num;
	logic        [3:0]        ref_sh;
	logic                     mul_done, div_done;
	logic        [PROD_W-1:0] prod;
	logic        [NUM_W-1:0]  quo;
	logic        [OUT_W-1:0]  quo_lo;
	logic                     out_free;

	// hold the run count inside its legal range
	always_comb begin
		n_eff = sample_count_q;
		if (sample_count_q < CNT_W'(MIN_SAMPLES)) n_eff = CNT_W'(MIN_SAMPLES);
		if (sample_count_q > CNT_W'(MAX_SAMPLES)) n_eff = CNT_W'(MAX_SAMPLES);
	end

	assign nm2      = NM2_W'(n_eff - CNT_W'(2));
	assign in_stall = run.fin || (state_q != ST_IDLE);
	assign take     = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign trim_nx  = (SUM_W+1)'(run.sum) - (SUM_W+1)'(run.min) - (SUM_W+1)'(run.max);
	assign gain_abs = channel_gain_q[GAIN_W-1] ? GAIN_W'(-channel_gain_q)
	                                           : GAIN_W'(channel_gain_q);
	assign trim_abs = trim_q[SUM_W] ? MAG_W'(-trim_q) : MAG_W'(trim_q);
	assign ref_sh   = 4'(REF_SHIFT) - {1'b0, pga_code_q};
	assign num      = NUM_W'(prod) << ref_sh;
	assign quo_lo   = quo[OUT_W-1:0];

	atms_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample (sample),
		.n_eff  (n_eff),
		.run    (run)
	);

	atms_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_PREP),
		.a      (trim_abs),
		.b      (gmag_q),
		.done   (mul_done),
		.prod   (prod)
	);

	atms_sdiv u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MUL && mul_done),
		.num    (num),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CNT_W'(5);
			pga_code_q     <= PGA_W'(2);
			channel_gain_q <= GAIN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data[CNT_W-1:0];
				REG_PGA_CODE:     pga_code_q     <= cfg_data[PGA_W-1:0];
				REG_CHANNEL_GAIN: channel_gain_q <= cfg_data[GAIN_W-1:0];
				default:          ;
			endcase
		end
	end

	// run sequencer with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a new word, or drop the old one once the receiver takes it
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (run.fin) state_q <= ST_PREP;
				ST_PREP: state_q <= ST_MUL;
				ST_MUL:  if (mul_done) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && run.fin) begin
			trim_q <= trim_nx;
			gmag_q <= GMUL_W'(gain_abs) * GMUL_W'(MV_TO_UV);
			den_q  <= DEN_W'({nm2, {FS_SHIFT{1'b0}}}) - DEN_W'(nm2);
			neg_q  <= trim_nx[SUM_W] ^ channel_gain_q[GAIN_W-1];
		end
		if (state_q == ST_OUT && out_free) begin
			measured_value_q <= neg_q ? -$signed(quo_lo) : $signed(quo_lo);
		end
	end

	assign out_valid      = out_valid_q;
	assign measured_value = measured_value_q;

endmodule

// ===== design/atms_accum.sv =====
// Running minimum, maximum, sum and count of one measurement run.
// Depends on atms_pkg.
module atms_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take,
	input  logic signed [atms_pkg::SAMPLE_W-1:0] sample,
	input  logic        [atms_pkg::CNT_W-1:0]    n_eff,
	output atms_pkg::run_t                       run
);
	import atms_pkg::*;

	logic signed [SAMPLE_W-1:0] min_q, max_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic        [CNT_W-1:0]    seen_q;
	logic                       fin_q;
	logic        [CNT_W-1:0]    seen_nx;

	assign seen_nx = (seen_q == {CNT_W{1'b1}}) ? seen_q : seen_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= '0;
			sum_q  <= '0;
			seen_q <= '0;
			fin_q  <= 1'b0;
		end else if (fin_q) begin
			// the scaler captures the run in this cycle; re-arm
			min_q  <= '0;
			max_q  <= '0;
			sum_q  <= '0;
			seen_q <= '0;
			fin_q  <= 1'b0;
		end else if (take) begin
			if (seen_q == '0) begin
				min_q <= sample;
				max_q <= sample;
				sum_q <= SUM_W'(sample);
			end else begin
				if (sample > max_q) max_q <= sample;
				if (sample < min_q) min_q <= sample;
				sum_q <= sum_q + SUM_W'(sample);
			end
			seen_q <= seen_nx;
			fin_q  <= (seen_nx >= n_eff);
		end
	end

	assign run.fin = fin_q;
	assign run.sum = sum_q;
	assign run.min = min_q;
	assign run.max = max_q;

endmodule

// ===== design/atms_smul.sv =====
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Depends on atms_pkg.
module atms_smul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [atms_pkg::MAG_W-1:0]    a,
	input  logic [atms_pkg::GMUL_W-1:0]   b,
	output logic                          done,
	output logic [atms_pkg::PROD_W-1:0]   prod
);
	import atms_pkg::*;

	logic [MAG_W-1:0]     a_q;
	logic [MAG_W-1:0]     hi_q;
	logic [GMUL_W-1:0]    lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [MAG_W:0]       part;

	// add the multiplicand when the low bit is set, then shift the pair right
	assign part = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(GMUL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= part[MAG_W:1];
			lo_q <= {part[0], lo_q[GMUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// ===== design/atms_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on atms_pkg.
module atms_sdiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [atms_pkg::NUM_W-1:0]  num,
	input  logic [atms_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [atms_pkg::NUM_W-1:0]  quo
);
	import atms_pkg::*;

	logic [NUM_W-1:0]     nq_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule
